// ===== rtl/core/plr_pkg.sv =====
// Shared types and constants for the pixel replicating line upscaler.
package plr_pkg;

  localparam int MAX_ROW_PIXELS_DEFAULT = 4096;
  localparam int QUEUE_DEPTH = 4;
  localparam int PIXEL_W = 24;
  localparam logic [6:0] SCALE_LIMIT = 7'd100;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_PIXEL  = 2'd1,
    CMD_PAD    = 2'd2,
    CMD_REJECT = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t              op;
    logic [PIXEL_W-1:0]   pixel;
    logic                 eol;
    logic                 eor;
  } cmd_meta_t;

endpackage

// ===== rtl/core/plr_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module plr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/plr_front.sv =====
// Front end: accepts items, keeps the row and replay counters, issues commands.
module plr_front
  import plr_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEFAULT,
  localparam int AW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1,
  localparam int CW = $clog2(MAX_ROW_PIXELS + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [6:0]      scale_factor,
  input  logic [12:0]     row_width,
  input  logic            in_accept,
  input  logic            opcode,
  input  logic [7:0]      in_blue,
  input  logic [7:0]      in_green,
  input  logic [7:0]      in_red,
  output logic            cmd_valid,
  output cmd_meta_t       cmd_meta,
  output logic [AW-1:0]   cmd_addr
);

  localparam logic OP_PUSH = 1'b0;
  localparam int WW = (CW > 13) ? CW : 13;
  localparam logic [WW-1:0] MAX_EXT = WW'(MAX_ROW_PIXELS);

  logic [CW-1:0] loaded_count, loaded_count_next;
  logic [CW-1:0] column_index, column_index_next;
  logic [6:0]    horizontal_repeat, horizontal_repeat_next;
  logic [6:0]    vertical_repeat, vertical_repeat_next;
  logic [1:0]    pad_emitted, pad_emitted_next;

  logic [6:0]    scale_eff;
  logic [WW-1:0] width_ext;
  logic [CW-1:0] width_eff;
  logic [3:0]    pad_prod;
  logic [1:0]    pad_bytes;
  logic          full;
  logic [7:0]    h_inc;
  logic [7:0]    v_inc;
  logic [CW-1:0] col_inc;
  logic [2:0]    pad_inc;
  logic          finish;

  always_comb begin
    if (scale_factor == 7'd0) begin
      scale_eff = 7'd1;
    end else if (scale_factor > SCALE_LIMIT) begin
      scale_eff = SCALE_LIMIT;
    end else begin
      scale_eff = scale_factor;
    end
    width_ext = WW'(row_width);
    if (row_width == 13'd0) begin
      width_eff = CW'(1);
    end else if (width_ext > MAX_EXT) begin
      width_eff = CW'(MAX_ROW_PIXELS);
    end else begin
      width_eff = CW'(width_ext);
    end
  end

  // Three bytes per pixel, so the pad to a four byte boundary is (width * scale) mod 4.
  assign pad_prod  = {2'b00, width_eff[(CW > 1) ? 1 : 0] & (CW > 1), width_eff[0]}
                     * {2'b00, scale_eff[1:0]};
  assign pad_bytes = pad_prod[1:0];
  assign full      = loaded_count >= width_eff;
  assign h_inc     = {1'b0, horizontal_repeat} + 8'd1;
  assign v_inc     = {1'b0, vertical_repeat} + 8'd1;
  assign col_inc   = column_index + CW'(1);
  assign pad_inc   = {1'b0, pad_emitted} + 3'd1;

  always_comb begin
    loaded_count_next      = loaded_count;
    column_index_next      = column_index;
    horizontal_repeat_next = horizontal_repeat;
    vertical_repeat_next   = vertical_repeat;
    pad_emitted_next       = pad_emitted;
    cmd_valid              = 1'b0;
    cmd_meta.op            = CMD_REJECT;
    cmd_meta.pixel         = {in_red, in_green, in_blue};
    cmd_meta.eol           = 1'b0;
    cmd_meta.eor           = 1'b0;
    cmd_addr               = column_index[AW-1:0];
    finish                 = 1'b0;

    if (in_accept) begin
      if (opcode == OP_PUSH) begin
        cmd_valid = 1'b1;
        if (full) begin
          cmd_meta.op = CMD_REJECT;
        end else begin
          cmd_meta.op       = CMD_WRITE;
          cmd_addr          = loaded_count[AW-1:0];
          loaded_count_next = loaded_count + CW'(1);
        end
      end else if (full) begin
        cmd_valid = 1'b1;
        if (column_index < width_eff) begin
          cmd_meta.op = CMD_PIXEL;
          if (h_inc >= {1'b0, scale_eff}) begin
            horizontal_repeat_next = 7'd0;
            column_index_next      = col_inc;
            if (col_inc >= width_eff && pad_bytes == 2'd0) begin
              finish = 1'b1;
            end
          end else begin
            horizontal_repeat_next = h_inc[6:0];
          end
        end else begin
          cmd_meta.op = CMD_PAD;
          if (pad_inc >= {1'b0, pad_bytes}) begin
            finish = 1'b1;
          end else begin
            pad_emitted_next = pad_inc[1:0];
          end
        end
      end
    end

    // Closing an output row rewinds the column and, after the last replay, empties the row.
    if (finish) begin
      cmd_meta.eol           = 1'b1;
      column_index_next      = '0;
      pad_emitted_next       = 2'd0;
      horizontal_repeat_next = 7'd0;
      if (v_inc >= {1'b0, scale_eff}) begin
        vertical_repeat_next = 7'd0;
        loaded_count_next    = '0;
        cmd_meta.eor         = 1'b1;
      end else begin
        vertical_repeat_next = v_inc[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count      <= '0;
      column_index      <= '0;
      horizontal_repeat <= 7'd0;
      vertical_repeat   <= 7'd0;
      pad_emitted       <= 2'd0;
    end else begin
      loaded_count      <= loaded_count_next;
      column_index      <= column_index_next;
      horizontal_repeat <= horizontal_repeat_next;
      vertical_repeat   <= vertical_repeat_next;
      pad_emitted       <= pad_emitted_next;
    end
  end

endmodule

// ===== rtl/core/plr_queue.sv =====
// Short command queue between the front end and the back end.
module plr_queue
  import plr_pkg::*;
#(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_meta_t     push_meta,
  input  logic [AW-1:0] push_addr,
  output logic          full,
  output logic          not_empty,
  input  logic          pop,
  output cmd_meta_t     head_meta,
  output logic [AW-1:0] head_addr
);

  localparam int QAW = $clog2(QUEUE_DEPTH);

  cmd_meta_t     meta_q [QUEUE_DEPTH];
  logic [AW-1:0] addr_q [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full      = count == (QAW + 1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head_meta = meta_q[rd_ptr];
  assign head_addr = addr_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      meta_q[wr_ptr] <= push_meta;
      addr_q[wr_ptr] <= push_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count + (QAW + 1)'(push) - (QAW + 1)'(pop);
    end
  end

endmodule

// ===== rtl/core/plr_back.sv =====
// Back end: executes buffer writes and reads, and registers the output items.
module plr_back
  import plr_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEFAULT,
  localparam int AW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_not_empty,
  input  cmd_meta_t     q_meta,
  input  logic [AW-1:0] q_addr,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    item_kind,
  output logic [7:0]    out_blue,
  output logic [7:0]    out_green,
  output logic [7:0]    out_red,
  output logic          end_of_line,
  output logic          end_of_replay
);

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_PAD    = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  logic               advance;
  logic               ram_we;
  logic               ram_re;
  logic [PIXEL_W-1:0] ram_rdata;
  logic               s1_valid;
  cmd_op_t            s1_op;
  logic               s1_eol;
  logic               s1_eor;

  // The read stage and the output register move together whenever the output is free.
  assign advance = !out_valid || !out_stall;
  assign q_pop   = q_not_empty && advance;
  assign ram_we  = q_pop && (q_meta.op == CMD_WRITE);
  assign ram_re  = q_pop && (q_meta.op == CMD_PIXEL);

  plr_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_ROW_PIXELS)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_addr),
    .wdata (q_meta.pixel),
    .re    (ram_re),
    .raddr (q_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= q_pop && (q_meta.op != CMD_WRITE);
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op         <= q_meta.op;
      s1_eol        <= q_meta.eol;
      s1_eor        <= q_meta.eor;
      end_of_line   <= s1_eol;
      end_of_replay <= s1_eor;
      case (s1_op)
        CMD_PIXEL: begin
          item_kind <= KIND_PIXEL;
          {out_red, out_green, out_blue} <= ram_rdata;
        end
        CMD_PAD: begin
          item_kind <= KIND_PAD;
          {out_red, out_green, out_blue} <= '0;
        end
        default: begin
          item_kind <= KIND_REJECT;
          {out_red, out_green, out_blue} <= '0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/pixel_replicating_line_upscaler.sv =====
// Top level of the pixel replicating line upscaler with its configuration registers.
// Throughput: one item per clock while the command queue has room and the output is not
// stalled, limited by the single line buffer port set in the back end. An accepted item
// passes through the command queue, the line buffer read stage and the output register.
// Reset (rst, synchronous, active high) empties the row, queue and output; scale_factor and
// row_width return to 1. The line buffer itself is not cleared.
module pixel_replicating_line_upscaler
  import plr_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  item_kind,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic        end_of_line,
  output logic        end_of_replay
);

  localparam int AW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  logic [6:0]    scale_factor;
  logic [12:0]   row_width;
  logic          cfg_write;
  logic          in_accept;

  logic          cmd_valid;
  cmd_meta_t     cmd_meta;
  logic [AW-1:0] cmd_addr;
  logic          q_full;
  logic          q_not_empty;
  logic          q_pop;
  cmd_meta_t     q_meta;
  logic [AW-1:0] q_addr;

  // Configuration registers. The port never inserts wait states; register i sits at byte
  // address 4*i, and the word address bit selects between the two registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= 7'd1;
      row_width    <= 13'd1;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_SCALE: scale_factor <= pwdata[6:0];
        REG_WIDTH: row_width    <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SCALE: prdata = {25'd0, scale_factor};
      REG_WIDTH: prdata = {19'd0, row_width};
      default:   prdata = '0;
    endcase
  end

  // An input transfer is taken whenever the command queue has room, so the front end keeps
  // working while the back end waits on a stalled output.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  // The front end owns every counter of the replay and turns each accepted item into at most
  // one command: a buffer write, a buffer read for an output pixel, a pad byte or a rejection.
  plr_front #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .scale_factor (scale_factor),
    .row_width    (row_width),
    .in_accept    (in_accept),
    .opcode       (opcode),
    .in_blue      (in_blue),
    .in_green     (in_green),
    .in_red       (in_red),
    .cmd_valid    (cmd_valid),
    .cmd_meta     (cmd_meta),
    .cmd_addr     (cmd_addr)
  );

  // Writes travel through the queue in order with reads, so a new row can never overwrite a
  // pixel that an earlier, still queued, read has yet to fetch.
  plr_queue #(
    .AW (AW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_valid),
    .push_meta (cmd_meta),
    .push_addr (cmd_addr),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .head_meta (q_meta),
    .head_addr (q_addr)
  );

  // The back end holds the line buffer and the output register, and stalls on its own.
  plr_back #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (q_not_empty),
    .q_meta        (q_meta),
    .q_addr        (q_addr),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .item_kind     (item_kind),
    .out_blue      (out_blue),
    .out_green     (out_green),
    .out_red       (out_red),
    .end_of_line   (end_of_line),
    .end_of_replay (end_of_replay)
  );

endmodule
